/* hw/rtl/abtt_pkg.sv */
// ----------------------------------------------------------------------------
// abtt_pkg
// shared types and codes for the heap-indexed binary tree block
// ----------------------------------------------------------------------------
package abtt_pkg;

   localparam int DATA_W = 16;

   // request action codes
   localparam logic ACT_INSERT   = 1'b0;
   localparam logic ACT_TRAVERSE = 1'b1;

   // traversal order codes, also used as the walk phase at a node
   localparam logic [1:0] ORD_PRE  = 2'd0;
   localparam logic [1:0] ORD_IN   = 2'd1;
   localparam logic [1:0] ORD_POST = 2'd2;

   // one slot of the tree store
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] value;
   } slot_type;

   // sequencer to result buffer
   typedef struct packed {
      logic              emit;
      logic              flush;
      logic [DATA_W-1:0] value;
   } out_cmd_type;

   // result buffer to sequencer
   typedef struct packed {
      logic out_ok;
      logic pend_vld;
   } out_stat_type;

endpackage

/* hw/rtl/abtt_req_if.sv */
// ----------------------------------------------------------------------------
// abtt_req_if
// request channel: valid/ready handshake with insert or traverse payload
// ----------------------------------------------------------------------------
interface abtt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [abtt_pkg::DATA_W-1:0] parent_value;
   logic [abtt_pkg::DATA_W-1:0] child_value;
   logic [1:0]                  order;

   modport source (output valid, action, parent_value, child_value, order, input ready);
   modport sink (input valid, action, parent_value, child_value, order, output ready);
endinterface

/* hw/rtl/abtt_rsp_if.sv */
// ----------------------------------------------------------------------------
// abtt_rsp_if
// result channel: valid/ready handshake with node value and last flag
// ----------------------------------------------------------------------------
interface abtt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [abtt_pkg::DATA_W-1:0] node_value;
   logic                        last;

   modport source (output valid, node_value, last, input ready);
   modport sink (input valid, node_value, last, output ready);
endinterface

/* hw/rtl/array_binary_tree_traversal.sv */
// ----------------------------------------------------------------------------
// array_binary_tree_traversal
// binary tree in a heap-indexed store with insert and three traversal orders
// ----------------------------------------------------------------------------
// The tree lives in a SLOTS-deep store: slot 1 is the root and slot k has its
// children at 2k and 2k+1. After reset a clearing pass over every slot runs
// before the first request is taken. An insert request scans slots 1 to
// SLOTS-1 through the store's two read ports, with a read state and an
// evaluate state per slot, and gives no result. A traverse request walks the
// tree without a stack, moving up and down by index with one store read per
// step; it is held up only while the result port stalls. Each node is one
// result, the final one flagged with last; order code 3 gives none. One
// request is handled at a time and req stays low until it completes; the
// last result may still be waiting on rsp.
// ----------------------------------------------------------------------------
module array_binary_tree_traversal #(
   parameter int SLOTS = 64
) (
   input logic        clock,
   input logic        reset,
   abtt_req_if.sink   req,
   abtt_rsp_if.source rsp
);

   localparam int IDX_W = $clog2(SLOTS);

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   abtt_pkg::slot_type     ram_wdata;
   logic [IDX_W-1:0]       ram_raddr_a;
   logic [IDX_W-1:0]       ram_raddr_b;
   abtt_pkg::slot_type     ram_rdata_a;
   abtt_pkg::slot_type     ram_rdata_b;
   abtt_pkg::out_cmd_type  out_cmd;
   abtt_pkg::out_stat_type out_stat;

   abtt_slot_ram #(.SLOTS(SLOTS)) u_ram (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   abtt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr_a (ram_raddr_a),
      .ram_raddr_b (ram_raddr_b),
      .ram_rdata_a (ram_rdata_a),
      .ram_rdata_b (ram_rdata_b),
      .out_cmd     (out_cmd),
      .out_stat    (out_stat)
   );

   abtt_out u_out (
      .clock (clock),
      .reset (reset),
      .cmd   (out_cmd),
      .stat  (out_stat),
      .rsp   (rsp)
   );

`ifndef SYNTH
   // a new request must not find a node of the previous traversal held back
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !out_stat.pend_vld)
      else $error("request taken with a node still pending");

   // a non-final result always has a successor waiting behind it
   a_open_run: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.last) |-> out_stat.pend_vld)
      else $error("non-final result with nothing pending");

   // the sequencer only pushes a node when the output side can take one
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (out_cmd.emit || out_cmd.flush) |-> out_stat.out_ok)
      else $error("node pushed while the output register is full");
`endif

endmodule

/* hw/rtl/abtt_slot_ram.sv */
// ----------------------------------------------------------------------------
// abtt_slot_ram
// tree store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module abtt_slot_ram #(
   parameter int SLOTS = 64,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [IDX_W-1:0]     waddr,
   input  abtt_pkg::slot_type   wdata,
   input  logic [IDX_W-1:0]     raddr_a,
   input  logic [IDX_W-1:0]     raddr_b,
   output abtt_pkg::slot_type   rdata_a,
   output abtt_pkg::slot_type   rdata_b
);

   abtt_pkg::slot_type mem [SLOTS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

/* hw/rtl/abtt_out.sv */
// ----------------------------------------------------------------------------
// abtt_out
// result buffer: holds one node back so the final one can carry last
// ----------------------------------------------------------------------------
module abtt_out (
   input  logic                   clock,
   input  logic                   reset,
   input  abtt_pkg::out_cmd_type  cmd,
   output abtt_pkg::out_stat_type stat,
   abtt_rsp_if.source             rsp
);

   logic                        out_vld_ff, out_vld_in;
   logic [abtt_pkg::DATA_W-1:0] out_val_ff, out_val_in;
   logic                        out_last_ff, out_last_in;
   logic                        pend_vld_ff, pend_vld_in;
   logic [abtt_pkg::DATA_W-1:0] pend_val_ff, pend_val_in;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_val_in  = out_val_ff;
      out_last_in = out_last_ff;
      pend_vld_in = pend_vld_ff;
      pend_val_in = pend_val_ff;
      if (out_vld_ff && rsp.ready) begin
         out_vld_in = 1'b0;
      end
      if (cmd.emit) begin
         if (pend_vld_ff) begin
            out_vld_in  = 1'b1;
            out_val_in  = pend_val_ff;
            out_last_in = 1'b0;
         end
         pend_vld_in = 1'b1;
         pend_val_in = cmd.value;
      end else if (cmd.flush && pend_vld_ff) begin
         out_vld_in  = 1'b1;
         out_val_in  = pend_val_ff;
         out_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
      out_val_ff  <= out_val_in;
      out_last_ff <= out_last_in;
      pend_val_ff <= pend_val_in;
   end

   assign stat.out_ok   = !out_vld_ff || rsp.ready;
   assign stat.pend_vld = pend_vld_ff;

   assign rsp.valid      = out_vld_ff;
   assign rsp.node_value = out_val_ff;
   assign rsp.last       = out_last_ff;

endmodule

/* hw/rtl/abtt_ctrl.sv */
// ----------------------------------------------------------------------------
// abtt_ctrl
// sequencer: store clearing, slot-by-slot insert walk and stackless traversal
// ----------------------------------------------------------------------------
module abtt_ctrl #(
   parameter int SLOTS = 64,
   localparam int IDX_W = $clog2(SLOTS)
) (
   input  logic                   clock,
   input  logic                   reset,
   abtt_req_if.sink               req,
   output logic                   ram_we,
   output logic [IDX_W-1:0]       ram_waddr,
   output abtt_pkg::slot_type     ram_wdata,
   output logic [IDX_W-1:0]       ram_raddr_a,
   output logic [IDX_W-1:0]       ram_raddr_b,
   input  abtt_pkg::slot_type     ram_rdata_a,
   input  abtt_pkg::slot_type     ram_rdata_b,
   output abtt_pkg::out_cmd_type  out_cmd,
   input  abtt_pkg::out_stat_type out_stat
);

   localparam int AW = IDX_W + 1;
   localparam logic [AW-1:0]    SLOTS_C = AW'(SLOTS);
   localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W-1:0] ROOT_K  = IDX_W'(1);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_INS_RD = 8'b0000_0100,
      ST_INS_EV = 8'b0000_1000,
      ST_NODE   = 8'b0001_0000,
      ST_LOOK   = 8'b0010_0000,
      ST_CHK    = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic [AW-1:0]               cand_ff, cand_in;
   logic                        up_ff, up_in;
   logic [1:0]                  ph_ff, ph_in;
   logic [1:0]                  nxt_ph_ff, nxt_ph_in;
   logic [abtt_pkg::DATA_W-1:0] val_ff, val_in;
   logic [abtt_pkg::DATA_W-1:0] parent_ff, parent_in;
   logic [abtt_pkg::DATA_W-1:0] child_ff, child_in;
   logic [1:0]                  order_ff, order_in;

   // per-slot "walk continues below" flag for the insert pass
   logic desc_mem [SLOTS];
   logic desc_rd_ff;
   logic desc_we;
   logic desc_wdata;

   logic [AW-1:0] left;
   logic [AW-1:0] right;
   logic          left_ok;
   logic          right_ok;
   logic          left_present;
   logic          reached;
   logic          match;
   logic          hit;

   assign left         = {k_ff, 1'b0};
   assign right        = {k_ff, 1'b1};
   assign left_ok      = left < SLOTS_C;
   assign right_ok     = right < SLOTS_C;
   assign left_present = left_ok && ram_rdata_b.valid;
   assign reached      = ram_rdata_a.valid && ((k_ff == ROOT_K) || desc_rd_ff);
   assign match        = reached && (ram_rdata_a.value == parent_ff);
   assign hit          = (ph_ff == order_ff);

   assign ram_raddr_a = (state_ff == ST_LOOK) ? cand_ff[IDX_W-1:0] : k_ff;
   assign ram_raddr_b = left[IDX_W-1:0];

   assign req.ready = (state_ff == ST_IDLE);

   assign desc_we    = (state_ff == ST_INS_EV);
   assign desc_wdata = reached && !match;

   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[k_ff] <= desc_wdata;
      end
      desc_rd_ff <= desc_mem[k_ff >> 1];
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cand_in   = cand_ff;
      up_in     = up_ff;
      ph_in     = ph_ff;
      nxt_ph_in = nxt_ph_ff;
      val_in    = val_ff;
      parent_in = parent_ff;
      child_in  = child_ff;
      order_in  = order_ff;

      ram_we          = 1'b0;
      ram_waddr       = k_ff;
      ram_wdata.valid = 1'b1;
      ram_wdata.value = child_ff;

      out_cmd.emit  = 1'b0;
      out_cmd.flush = 1'b0;
      out_cmd.value = val_ff;

      case (state_ff)
         ST_CLEAR: begin
            // only the root survives reset
            ram_we          = 1'b1;
            ram_waddr       = k_ff;
            ram_wdata.valid = (k_ff == ROOT_K);
            ram_wdata.value = abtt_pkg::DATA_W'(k_ff == ROOT_K);
            k_in            = k_ff + 1'b1;
            if (k_ff == LAST_K) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               parent_in = req.parent_value;
               child_in  = req.child_value;
               order_in  = req.order;
               k_in      = ROOT_K;
               if (req.action == abtt_pkg::ACT_INSERT) begin
                  state_in = ST_INS_RD;
               end else if (req.order inside {abtt_pkg::ORD_PRE, abtt_pkg::ORD_IN,
                                              abtt_pkg::ORD_POST}) begin
                  cand_in   = AW'(1);
                  up_in     = 1'b1;
                  nxt_ph_in = abtt_pkg::ORD_PRE;
                  state_in  = ST_LOOK;
               end
            end
         end
         ST_INS_RD: begin
            state_in = ST_INS_EV;
         end
         ST_INS_EV: begin
            if (match) begin
               if (!left_present && left_ok) begin
                  ram_we    = 1'b1;
                  ram_waddr = left[IDX_W-1:0];
               end else if (left_present && right_ok) begin
                  ram_we    = 1'b1;
                  ram_waddr = right[IDX_W-1:0];
               end
            end
            k_in = k_ff + 1'b1;
            if (k_ff == LAST_K) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_INS_RD;
            end
         end
         ST_NODE: begin
            if (!hit || out_stat.out_ok) begin
               out_cmd.emit = hit;
               state_in     = ST_LOOK;
               case (ph_ff)
                  abtt_pkg::ORD_PRE: begin
                     cand_in   = left;
                     up_in     = 1'b0;
                     nxt_ph_in = abtt_pkg::ORD_IN;
                  end
                  abtt_pkg::ORD_IN: begin
                     cand_in   = right;
                     up_in     = 1'b0;
                     nxt_ph_in = abtt_pkg::ORD_POST;
                  end
                  abtt_pkg::ORD_POST: begin
                     if (k_ff == ROOT_K) begin
                        state_in = ST_FIN;
                     end else begin
                        // climb: a right child returns to its parent's post phase
                        cand_in   = AW'(k_ff >> 1);
                        up_in     = 1'b1;
                        nxt_ph_in = k_ff[0] ? abtt_pkg::ORD_POST : abtt_pkg::ORD_IN;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            state_in = ST_NODE;
            if (up_ff || ((cand_ff < SLOTS_C) && ram_rdata_a.valid)) begin
               k_in   = cand_ff[IDX_W-1:0];
               val_in = ram_rdata_a.value;
               ph_in  = up_ff ? nxt_ph_ff : abtt_pkg::ORD_PRE;
            end else begin
               ph_in = nxt_ph_ff;
            end
         end
         ST_FIN: begin
            if (out_stat.out_ok) begin
               out_cmd.flush = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
      cand_ff   <= cand_in;
      up_ff     <= up_in;
      ph_ff     <= ph_in;
      nxt_ph_ff <= nxt_ph_in;
      val_ff    <= val_in;
      parent_ff <= parent_in;
      child_ff  <= child_in;
      order_ff  <= order_in;
   end

endmodule

/* dv/array_binary_tree_traversal_tb.sv */
// ----------------------------------------------------------------------------
// array_binary_tree_traversal_tb
// self-checking bench for the heap-indexed binary tree block
// ----------------------------------------------------------------------------
// Sends insert and traverse requests through the request channel. A
// scoreboard keeps its own copy of the tree store, works out the node values
// that each traversal should return, and checks every result in order. Both
// channels idle and stall at random. A short directed opening builds a deep
// chain and hits the duplicate, overwrite and out-of-capacity cases. After it
// come random requests whose parents are mostly values already in the tree.
// ----------------------------------------------------------------------------
module array_binary_tree_traversal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TREE_SLOTS      = 64;
   localparam logic [1:0] ORD_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 180;
   // the limit covers a whole insert scan plus the longest stall or gap
   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 2 * TREE_SLOTS + 16;

   class tree_scoreboard;
      typedef struct {
         logic [abtt_pkg::DATA_W-1:0] value;
         logic                        last;
      } node_result_type;

      logic [abtt_pkg::DATA_W-1:0] slot_value [TREE_SLOTS];
      bit                          slot_valid [TREE_SLOTS];
      node_result_type             expected_nodes [$];
      int                          errors;
      int                          inserts;
      int                          traversals;
      int                          nodes_checked;

      function new();
         foreach (slot_valid[k]) begin
            slot_valid[k] = 1'b0;
            slot_value[k] = '0;
         end
         slot_valid[1] = 1'b1;
         slot_value[1] = abtt_pkg::DATA_W'(1);
         errors        = 0;
         inserts       = 0;
         traversals    = 0;
         nodes_checked = 0;
      endfunction

      // indexes beyond the store count as empty
      function bit in_tree(int unsigned k);
         return k < TREE_SLOTS && slot_valid[k];
      endfunction

      function void grow_tree(logic [abtt_pkg::DATA_W-1:0] parent,
                              logic [abtt_pkg::DATA_W-1:0] child);
         bit          reached [TREE_SLOTS];
         bit          stopped [TREE_SLOTS];
         int unsigned left;
         foreach (reached[k]) begin
            reached[k] = 1'b0;
            stopped[k] = 1'b0;
         end
         for (int unsigned k = 1; k < TREE_SLOTS; k++) begin
            reached[k] = slot_valid[k] && (k == 1 || (reached[k / 2] && !stopped[k / 2]));
            if (reached[k] && slot_value[k] == parent) begin
               // no descent below a matching node
               stopped[k] = 1'b1;
               left       = 2 * k;
               if (!in_tree(left)) begin
                  if (left < TREE_SLOTS) begin
                     slot_value[left] = child;
                     slot_valid[left] = 1'b1;
                  end
               end else if (left + 1 < TREE_SLOTS) begin
                  slot_value[left + 1] = child;
                  slot_valid[left + 1] = 1'b1;
               end
            end
         end
      endfunction

      // each visit is packed as 4*slot + phase, phase uses the order codes
      function void list_nodes(logic [1:0] ord);
         int unsigned pending_visits [$];
         int unsigned top;
         int unsigned k;
         logic [1:0]  phase;
         int          first_new;
         first_new = expected_nodes.size();
         pending_visits.push_back(4 + abtt_pkg::ORD_PRE);
         while (pending_visits.size() > 0) begin
            top   = pending_visits.pop_back();
            k     = top / 4;
            phase = top[1:0];
            if (phase == abtt_pkg::ORD_PRE && !in_tree(k)) continue;
            if (phase == ord) expected_nodes.push_back('{value: slot_value[k], last: 1'b0});
            if (phase == abtt_pkg::ORD_PRE) begin
               pending_visits.push_back(4 * k + abtt_pkg::ORD_IN);
               pending_visits.push_back(4 * (2 * k) + abtt_pkg::ORD_PRE);
            end else if (phase == abtt_pkg::ORD_IN) begin
               pending_visits.push_back(4 * k + abtt_pkg::ORD_POST);
               pending_visits.push_back(4 * (2 * k + 1) + abtt_pkg::ORD_PRE);
            end
         end
         if (expected_nodes.size() > first_new)
            expected_nodes[expected_nodes.size() - 1].last = 1'b1;
      endfunction

      function void note_request(logic act, logic [abtt_pkg::DATA_W-1:0] parent,
                                 logic [abtt_pkg::DATA_W-1:0] child, logic [1:0] ord);
         if (act == abtt_pkg::ACT_INSERT) begin
            inserts++;
            grow_tree(parent, child);
         end else begin
            traversals++;
            if (ord != ORD_UNUSED) list_nodes(ord);
         end
      endfunction

      function void check_result(logic [abtt_pkg::DATA_W-1:0] value, logic last);
         node_result_type want;
         if (expected_nodes.size() == 0) begin
            $error("unexpected result: node_value %h last %b", value, last);
            errors++;
            return;
         end
         want = expected_nodes.pop_front();
         nodes_checked++;
         if (value !== want.value) begin
            $error("node_value: expected %h, got %h", want.value, value);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
         end
      endfunction

      function logic [abtt_pkg::DATA_W-1:0] stored_value();
         int unsigned k;
         do k = $urandom_range(1, TREE_SLOTS - 1); while (!slot_valid[k]);
         return slot_value[k];
      endfunction

      function int filled_slots();
         int n;
         n = 0;
         foreach (slot_valid[k]) n += slot_valid[k];
         return n;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   abtt_req_if req_ch ();
   abtt_rsp_if rsp_ch ();

   array_binary_tree_traversal #(.SLOTS(TREE_SLOTS)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   tree_scoreboard sb;
   int             sent        = 0;
   int             idle_cycles = 0;
   int             stall_left  = 0;
   longint         cycle_count = 0;

   always #6ns clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // every third stretch of thirty requests goes back to back
   function automatic int sender_gap(int n);
      if ((n / 30) % 3 == 1 || $urandom_range(0, 1) == 0) return 0;
      return pick_gap();
   endfunction

   function automatic logic [abtt_pkg::DATA_W-1:0] random_child();
      case ($urandom_range(0, 9))
         0, 1:    return abtt_pkg::DATA_W'($urandom_range(0, 7));
         2, 3:    return sb.stored_value();
         default: return abtt_pkg::DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [abtt_pkg::DATA_W-1:0] random_value();
      return abtt_pkg::DATA_W'($urandom_range(0, 65535));
   endfunction

   task automatic send_request(input logic act, input logic [abtt_pkg::DATA_W-1:0] parent,
                               input logic [abtt_pkg::DATA_W-1:0] child,
                               input logic [1:0] ord);
      int gap;
      gap = sender_gap(sent);
      sent++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= act;
      req_ch.parent_value <= parent;
      req_ch.child_value  <= child;
      req_ch.order        <= ord;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(act, parent, child, ord);
   endtask

   task automatic insert_child(input logic [abtt_pkg::DATA_W-1:0] parent,
                               input logic [abtt_pkg::DATA_W-1:0] child);
      send_request(abtt_pkg::ACT_INSERT, parent, child, 2'($urandom_range(0, 3)));
   endtask

   task automatic traverse_tree(input logic [1:0] ord);
      send_request(abtt_pkg::ACT_TRAVERSE, random_value(), random_value(), ord);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_nodes.size() != 0);
   endtask

   initial rsp_ch.ready = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if ((cycle_count / 500) % 3 == 0 || $urandom_range(0, 99) < 75) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= pick_gap();
      end
   end

   // result check and watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.node_value, rsp_ch.last);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("array_binary_tree_traversal verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      sb = new();
      req_ch.valid        <= 1'b0;
      req_ch.action       <= abtt_pkg::ACT_INSERT;
      req_ch.parent_value <= '0;
      req_ch.child_value  <= '0;
      req_ch.order        <= abtt_pkg::ORD_PRE;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // root only, every order code
      traverse_tree(abtt_pkg::ORD_PRE);
      traverse_tree(abtt_pkg::ORD_IN);
      traverse_tree(abtt_pkg::ORD_POST);
      traverse_tree(ORD_UNUSED);
      // duplicate of the root sits below a match and is never reached
      insert_child(16'h0001, 16'h0001);
      insert_child(16'h0001, 16'hFFFF);
      // right child overwritten
      insert_child(16'h0001, 16'h8000);
      insert_child(16'h1234, 16'h0005);
      // chain of left children below the root's right child down to the deepest level
      insert_child(16'h8000, 16'h0000);
      insert_child(16'h0000, 16'hFFFF);
      insert_child(16'hFFFF, 16'h0007);
      insert_child(16'h0007, 16'h0009);
      // children of the deepest level fall outside the store
      insert_child(16'h0009, 16'h00AA);
      // overwrite a right child that still has a subtree
      insert_child(16'h0001, 16'h0002);
      insert_child(16'hFFFF, 16'hFFFF);
      traverse_tree(abtt_pkg::ORD_PRE);
      traverse_tree(abtt_pkg::ORD_IN);
      traverse_tree(abtt_pkg::ORD_POST);
      traverse_tree(ORD_UNUSED);
      wait_for_results();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 60 == 30) wait_for_results();
         pick = $urandom_range(0, 99);
         if (pick < 65) insert_child(sb.stored_value(), random_child());
         else if (pick < 75) insert_child(random_value(), random_child());
         else if (pick < 97) traverse_tree(2'($urandom_range(0, 2)));
         else traverse_tree(ORD_UNUSED);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d requests sent: %0d inserts and %0d traversals",
               sb.inserts + sb.traversals, sb.inserts, sb.traversals);
      $display("%0d tree nodes checked, %0d of %0d slots filled at the end",
               sb.nodes_checked, sb.filled_slots(), TREE_SLOTS - 1);
      if (sb.errors == 0)
         $display("array_binary_tree_traversal verification clean");
      else
         $display("array_binary_tree_traversal verification failed");
      $finish;
   end

endmodule
